// ===== hw/rtl/fence_deferred_slot_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// fence_deferred_slot_allocator_assert.svh
// assertion macros shared by the slot allocator rtl
// ----------------------------------------------------------------------------
`ifndef FENCE_DEFERRED_SLOT_ALLOCATOR_ASSERT_SVH
`define FENCE_DEFERRED_SLOT_ALLOCATOR_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define FDSA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("slot allocator assertion failed");

// next-cycle implication, disabled while reset is asserted
`define FDSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("slot allocator assertion failed");

`endif

// ===== hw/rtl/fdsa_pkg.sv =====
// ----------------------------------------------------------------------------
// fdsa_pkg
// types, constants and helpers of the fence deferred slot allocator
// ----------------------------------------------------------------------------
package fdsa_pkg;

	localparam int SLOT_COUNT = 1024;
	localparam int SLOT_W     = $clog2(SLOT_COUNT);
	localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
	localparam int FENCE_W    = 64;
	localparam int OP_W       = 2;
	localparam int STATUS_W   = 2;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_RETIRE  = 2'd2,
		OP_QUERY   = 2'd3
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_RANGE  = 2'd2,
		ST_DOUBLE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_FINISH,
		S_RETIRE
	} state_t;

	// one entry of the pending queue
	typedef struct packed {
		logic [SLOT_W-1:0]  slot;
		logic [FENCE_W-1:0] fence;
	} pend_entry_t;

	localparam int PEND_W = $bits(pend_entry_t);

	// circular pointer increment over the slot count
	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] p);
		logic [SLOT_W-1:0] r;
		if (p == SLOT_W'(SLOT_COUNT - 1)) begin
			r = '0;
		end else begin
			r = p + SLOT_W'(1);
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/fdsa_req_if.sv =====
// ----------------------------------------------------------------------------
// fdsa_req_if
// request channel of the slot allocator: valid, ready and one request item
// ----------------------------------------------------------------------------
interface fdsa_req_if;

	logic                        valid;
	logic                        ready;
	logic [fdsa_pkg::OP_W-1:0]   opcode;
	logic [fdsa_pkg::SLOT_W-1:0] slot_index;
	logic [fdsa_pkg::FENCE_W-1:0] fence_value;

	modport source (output valid, output opcode, output slot_index, output fence_value,
		input ready);
	modport sink (input valid, input opcode, input slot_index, input fence_value,
		output ready);

endinterface

// ===== hw/rtl/fdsa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// fdsa_rsp_if
// response channel of the slot allocator: valid, ready and one result item
// ----------------------------------------------------------------------------
interface fdsa_rsp_if;

	logic                          valid;
	logic                          ready;
	logic [fdsa_pkg::STATUS_W-1:0] status;
	logic [fdsa_pkg::SLOT_W-1:0]   granted_slot;
	logic                          is_allocated;
	logic [fdsa_pkg::CNT_W-1:0]    used_count;
	logic [fdsa_pkg::CNT_W-1:0]    retired_count;

	modport source (output valid, output status, output granted_slot, output is_allocated,
		output used_count, output retired_count, input ready);
	modport sink (input valid, input status, input granted_slot, input is_allocated,
		input used_count, input retired_count, output ready);

endinterface

// ===== hw/rtl/fdsa_ram.sv =====
// ----------------------------------------------------------------------------
// fdsa_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module fdsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, holds while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/fence_deferred_slot_allocator.sv =====
// allocate, release and query: accepted in the idle state, then finished in the finish state, where
//   the result is registered; no new item is taken until the block is back in idle
// retire: one pending queue read per cycle for each moved slot, then the result is registered
// a result waiting in the output register stalls only the finishing step of an item, not the retire moves
// reset: asynchronous, then a clearing pass over all SLOT_COUNT (1024) entries of the
//   allocated flag memory during which no item is accepted
// ----------------------------------------------------------------------------
// fence_deferred_slot_allocator
// slot allocator with a free fifo, a bump pointer and fence deferred release
// ----------------------------------------------------------------------------
`include "fence_deferred_slot_allocator_assert.svh"

module fence_deferred_slot_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [fdsa_pkg::CNT_W-1:0]  cfg_wdata,
	fdsa_req_if.sink                    req,
	fdsa_rsp_if.source                  rsp
);

	localparam int SW = fdsa_pkg::SLOT_W;
	localparam int CW = fdsa_pkg::CNT_W;

	// control state
	fdsa_pkg::state_t state_q, state_d;
	logic [CW-1:0] cap_q;
	logic [SW-1:0] clr_q, clr_d;
	logic [SW-1:0] free_head_q, free_head_d, free_tail_q, free_tail_d;
	logic [CW-1:0] free_count_q, free_count_d;
	logic [SW-1:0] pend_head_q, pend_head_d, pend_tail_q, pend_tail_d;
	logic [CW-1:0] pend_count_q, pend_count_d;
	logic [CW-1:0] bump_q, bump_d;
	logic [CW-1:0] used_q, used_d;
	logic [CW-1:0] moved_q, moved_d;
	logic          rsp_valid_q, rsp_valid_d;

	// item and result payload
	logic [fdsa_pkg::OP_W-1:0]    op_q;
	logic [SW-1:0]                idx_q;
	logic [fdsa_pkg::FENCE_W-1:0] fence_q;
	logic [fdsa_pkg::STATUS_W-1:0] status_q, status_d;
	logic [SW-1:0] granted_q, granted_d;
	logic          isalloc_q, isalloc_d;
	logic [CW-1:0] used_out_q, used_out_d;
	logic [CW-1:0] retired_q, retired_d;
	logic          load_out;

	// memory ports
	logic          flag_we, flag_wdata, flag_rdata;
	logic [SW-1:0] flag_waddr;
	logic          free_we;
	logic [SW-1:0] free_rdata;
	logic          pend_we, pend_re;
	logic [SW-1:0] pend_raddr;
	fdsa_pkg::pend_entry_t pend_wentry, pend_rentry;
	logic [fdsa_pkg::PEND_W-1:0] pend_rdata;

	logic          accept, out_busy, in_range, move;
	logic [CW-1:0] cap_eff;

	assign accept   = req.valid && req.ready;
	assign out_busy = rsp_valid_q && !rsp.ready;
	assign req.ready = (state_q == fdsa_pkg::S_IDLE);

	// capacity clamped to the built slot count
	assign cap_eff  = (cap_q > CW'(fdsa_pkg::SLOT_COUNT)) ? CW'(fdsa_pkg::SLOT_COUNT) : cap_q;
	assign in_range = ({1'b0, idx_q} < cap_eff);
	assign pend_rentry = fdsa_pkg::pend_entry_t'(pend_rdata);
	assign move     = (pend_count_q != '0) && (pend_rentry.fence <= fence_q);

	// allocated flags
	fdsa_ram #(.WIDTH(1), .DEPTH(fdsa_pkg::SLOT_COUNT)) u_flag_ram (
		.clk   (clk),
		.we    (flag_we),
		.waddr (flag_waddr),
		.wdata (flag_wdata),
		.re    (accept),
		.raddr (req.slot_index),
		.rdata (flag_rdata)
	);

	// free slot fifo
	fdsa_ram #(.WIDTH(SW), .DEPTH(fdsa_pkg::SLOT_COUNT)) u_free_ram (
		.clk   (clk),
		.we    (free_we),
		.waddr (free_tail_q),
		.wdata (pend_rentry.slot),
		.re    (accept),
		.raddr (free_head_q),
		.rdata (free_rdata)
	);

	// pending queue of slot and retire fence
	fdsa_ram #(.WIDTH(fdsa_pkg::PEND_W), .DEPTH(fdsa_pkg::SLOT_COUNT)) u_pend_ram (
		.clk   (clk),
		.we    (pend_we),
		.waddr (pend_tail_q),
		.wdata (pend_wentry),
		.re    (pend_re),
		.raddr (pend_raddr),
		.rdata (pend_rdata)
	);

	assign pend_wentry.slot  = idx_q;
	assign pend_wentry.fence = fence_q;

	// next state, memory writes and result
	always_comb begin
		state_d      = state_q;
		clr_d        = clr_q;
		free_head_d  = free_head_q;
		free_tail_d  = free_tail_q;
		free_count_d = free_count_q;
		pend_head_d  = pend_head_q;
		pend_tail_d  = pend_tail_q;
		pend_count_d = pend_count_q;
		bump_d       = bump_q;
		used_d       = used_q;
		moved_d      = moved_q;
		flag_we      = 1'b0;
		flag_waddr   = clr_q;
		flag_wdata   = 1'b0;
		free_we      = 1'b0;
		pend_we      = 1'b0;
		pend_re      = accept;
		pend_raddr   = pend_head_q;
		load_out     = 1'b0;
		status_d     = fdsa_pkg::ST_OK;
		granted_d    = '0;
		isalloc_d    = 1'b0;
		retired_d    = '0;

		case (state_q)
			fdsa_pkg::S_CLEAR: begin
				flag_we = 1'b1;
				clr_d   = clr_q + SW'(1);
				if (clr_q == SW'(fdsa_pkg::SLOT_COUNT - 1)) begin
					state_d = fdsa_pkg::S_IDLE;
				end
			end
			fdsa_pkg::S_IDLE: begin
				moved_d = '0;
				if (accept) begin
					state_d = (req.opcode == fdsa_pkg::OP_RETIRE) ? fdsa_pkg::S_RETIRE
						: fdsa_pkg::S_FINISH;
				end
			end
			fdsa_pkg::S_FINISH: begin
				if (!out_busy) begin
					load_out = 1'b1;
					state_d  = fdsa_pkg::S_IDLE;
					case (op_q)
						fdsa_pkg::OP_ALLOC: begin
							if (free_count_q != '0) begin
								// reuse a retired slot
								flag_we      = 1'b1;
								flag_waddr   = free_rdata;
								flag_wdata   = 1'b1;
								granted_d    = free_rdata;
								free_head_d  = fdsa_pkg::slot_inc(free_head_q);
								free_count_d = free_count_q - CW'(1);
								used_d       = used_q + CW'(1);
							end else if (bump_q < cap_eff) begin
								// never used slot from the bump pointer
								flag_we    = 1'b1;
								flag_waddr = bump_q[SW-1:0];
								flag_wdata = 1'b1;
								granted_d  = bump_q[SW-1:0];
								bump_d     = bump_q + CW'(1);
								used_d     = used_q + CW'(1);
							end else begin
								status_d = fdsa_pkg::ST_FULL;
							end
						end
						fdsa_pkg::OP_RELEASE: begin
							if (!in_range) begin
								status_d = fdsa_pkg::ST_RANGE;
							end else if (!flag_rdata) begin
								status_d = fdsa_pkg::ST_DOUBLE;
							end else begin
								flag_we    = 1'b1;
								flag_waddr = idx_q;
								flag_wdata = 1'b0;
								if (used_q != '0) begin
									used_d = used_q - CW'(1);
								end
								if (pend_count_q < CW'(fdsa_pkg::SLOT_COUNT)) begin
									pend_we      = 1'b1;
									pend_tail_d  = fdsa_pkg::slot_inc(pend_tail_q);
									pend_count_d = pend_count_q + CW'(1);
								end
							end
						end
						fdsa_pkg::OP_QUERY: begin
							isalloc_d = in_range && flag_rdata;
						end
						default: begin
							status_d = fdsa_pkg::ST_OK;
						end
					endcase
				end
			end
			fdsa_pkg::S_RETIRE: begin
				if (move) begin
					// move the queue head to the free fifo, fetch the next head
					if (free_count_q < CW'(fdsa_pkg::SLOT_COUNT)) begin
						free_we      = 1'b1;
						free_tail_d  = fdsa_pkg::slot_inc(free_tail_q);
						free_count_d = free_count_q + CW'(1);
					end
					pend_head_d  = fdsa_pkg::slot_inc(pend_head_q);
					pend_count_d = pend_count_q - CW'(1);
					moved_d      = moved_q + CW'(1);
					pend_re      = 1'b1;
					pend_raddr   = pend_head_d;
				end else if (!out_busy) begin
					load_out  = 1'b1;
					retired_d = moved_q;
					state_d   = fdsa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = fdsa_pkg::S_IDLE;
			end
		endcase

		used_out_d = used_d;
		rsp_valid_d = load_out ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_q);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= fdsa_pkg::S_CLEAR;
			clr_q        <= '0;
			free_head_q  <= '0;
			free_tail_q  <= '0;
			free_count_q <= '0;
			pend_head_q  <= '0;
			pend_tail_q  <= '0;
			pend_count_q <= '0;
			bump_q       <= '0;
			used_q       <= '0;
			moved_q      <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			clr_q        <= clr_d;
			free_head_q  <= free_head_d;
			free_tail_q  <= free_tail_d;
			free_count_q <= free_count_d;
			pend_head_q  <= pend_head_d;
			pend_tail_q  <= pend_tail_d;
			pend_count_q <= pend_count_d;
			bump_q       <= bump_d;
			used_q       <= used_d;
			moved_q      <= moved_d;
			rsp_valid_q  <= rsp_valid_d;
		end
	end

	// capacity register, a zero write is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CW'(fdsa_pkg::SLOT_COUNT);
		end else if (cfg_we && (cfg_wdata != '0)) begin
			cap_q <= cfg_wdata;
		end
	end

	// captured item
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= req.opcode;
			idx_q   <= req.slot_index;
			fence_q <= req.fence_value;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q   <= status_d;
			granted_q  <= granted_d;
			isalloc_q  <= isalloc_d;
			used_out_q <= used_out_d;
			retired_q  <= retired_d;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.granted_slot  = granted_q;
	assign rsp.is_allocated  = isalloc_q;
	assign rsp.used_count    = used_out_q;
	assign rsp.retired_count = retired_q;

	// every slot taken from the bump pointer is in use, pending or free
	`FDSA_ASSERT_NOW(a_slot_conservation, clk, arst_n, 1'b1, ((CW+2)'(free_count_q) + (CW+2)'(pend_count_q) + (CW+2)'(used_q)) == (CW+2)'(bump_q))
	// no item enters during the flag clearing pass
	`FDSA_ASSERT_NOW(a_no_accept_in_clear, clk, arst_n, state_q == fdsa_pkg::S_CLEAR, !req.ready)
	// one item at a time
	`FDSA_ASSERT_NEXT(a_one_in_flight, clk, arst_n, accept, !req.ready)

endmodule

// ===== tb/fence_deferred_slot_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// fence_deferred_slot_allocator_tb
// self-checking bench for the slot allocator: a directed table of requests,
// then random allocate/release/retire/query traffic under three handshake
// idle mixes and several capacities, each reply compared against its typed
// table value or a local bookkeeping copy of the free list, the pending fence queue and the flags
// ----------------------------------------------------------------------------
module fence_deferred_slot_allocator_tb;

	typedef struct packed {
		fdsa_pkg::status_t                 status;
		logic [fdsa_pkg::SLOT_W-1:0]       granted;
		logic                              alloc;
		logic [fdsa_pkg::CNT_W-1:0]        used;
		logic [fdsa_pkg::CNT_W-1:0]        retired;
	} reply_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t                         kind;
		fdsa_pkg::opcode_t                 op;
		logic [fdsa_pkg::SLOT_W-1:0]       idx;
		logic [fdsa_pkg::FENCE_W-1:0]      fence;
		logic [fdsa_pkg::CNT_W-1:0]        cfg_val;
		bit                                typed;
		reply_t                            want;
	} dir_row_t;

	localparam logic [fdsa_pkg::FENCE_W-1:0] FENCE_MAX = '1;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [fdsa_pkg::CNT_W-1:0] cfg_wdata;

	fdsa_req_if req_ch();
	fdsa_rsp_if rsp_ch();

	fence_deferred_slot_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	always #5 clk = ~clk;

	// bookkeeping copy of the allocator
	logic [fdsa_pkg::CNT_W-1:0]  cap_reg;
	bit                          alloc_flag [fdsa_pkg::SLOT_COUNT];
	logic [fdsa_pkg::SLOT_W-1:0] free_slots [$];
	fdsa_pkg::pend_entry_t       fence_wait [$];
	logic [fdsa_pkg::CNT_W-1:0]  bump_ptr;
	logic [fdsa_pkg::CNT_W-1:0]  in_use;

	reply_t   reply_fifo [$];
	dir_row_t dir_rows [$];
	int       mismatches = 0;
	int       send_idle = 0;
	int       recv_idle = 0;
	int       hold_left = 0;
	logic [fdsa_pkg::FENCE_W-1:0] fence_now = 64'd1000;

	function automatic int eff_capacity();
		return (cap_reg > fdsa_pkg::CNT_W'(fdsa_pkg::SLOT_COUNT)) ? fdsa_pkg::SLOT_COUNT
			: int'(cap_reg);
	endfunction

	// advance the bookkeeping by one request and return its reply
	function automatic reply_t allocator_reply(fdsa_pkg::opcode_t op,
		logic [fdsa_pkg::SLOT_W-1:0] idx, logic [fdsa_pkg::FENCE_W-1:0] fence);
		reply_t r;
		int cap;
		logic [fdsa_pkg::SLOT_W-1:0] slot;
		fdsa_pkg::pend_entry_t ent;
		cap = eff_capacity();
		r = '0;
		r.status = fdsa_pkg::ST_OK;
		case (op)
			fdsa_pkg::OP_ALLOC: begin
				if (free_slots.size() > 0) begin
					slot = free_slots.pop_front();
					alloc_flag[slot] = 1'b1;
					in_use++;
					r.granted = slot;
				end else if (int'(bump_ptr) < cap) begin
					slot = bump_ptr[fdsa_pkg::SLOT_W-1:0];
					bump_ptr++;
					alloc_flag[slot] = 1'b1;
					in_use++;
					r.granted = slot;
				end else begin
					r.status = fdsa_pkg::ST_FULL;
				end
			end
			fdsa_pkg::OP_RELEASE: begin
				if (int'(idx) >= cap) begin
					r.status = fdsa_pkg::ST_RANGE;
				end else if (!alloc_flag[idx]) begin
					r.status = fdsa_pkg::ST_DOUBLE;
				end else begin
					alloc_flag[idx] = 1'b0;
					if (in_use > 0) in_use--;
					ent.slot = idx;
					ent.fence = fence;
					fence_wait.push_back(ent);
				end
			end
			fdsa_pkg::OP_RETIRE: begin
				// stops at the first entry whose fence has not completed
				while (fence_wait.size() > 0 && fence_wait[0].fence <= fence) begin
					ent = fence_wait.pop_front();
					free_slots.push_back(ent.slot);
					r.retired++;
				end
			end
			default: begin
				r.alloc = (int'(idx) < cap) && alloc_flag[idx];
			end
		endcase
		r.used = in_use;
		return r;
	endfunction

	// directed table builders
	task automatic row_item(fdsa_pkg::opcode_t op, int idx,
		logic [fdsa_pkg::FENCE_W-1:0] fence);
		dir_row_t row;
		row.kind = ROW_ITEM;
		row.op = op;
		row.idx = fdsa_pkg::SLOT_W'(idx);
		row.fence = fence;
		row.cfg_val = '0;
		row.typed = 1'b0;
		row.want = '0;
		dir_rows.push_back(row);
	endtask

	task automatic row_typed(fdsa_pkg::opcode_t op, int idx,
		logic [fdsa_pkg::FENCE_W-1:0] fence, fdsa_pkg::status_t st,
		int gr, bit ia, int used, int ret);
		dir_row_t row;
		row.kind = ROW_ITEM;
		row.op = op;
		row.idx = fdsa_pkg::SLOT_W'(idx);
		row.fence = fence;
		row.cfg_val = '0;
		row.typed = 1'b1;
		row.want.status = st;
		row.want.granted = fdsa_pkg::SLOT_W'(gr);
		row.want.alloc = ia;
		row.want.used = fdsa_pkg::CNT_W'(used);
		row.want.retired = fdsa_pkg::CNT_W'(ret);
		dir_rows.push_back(row);
	endtask

	task automatic row_cfg(int val);
		dir_row_t row;
		row.kind = ROW_CFG;
		row.op = fdsa_pkg::OP_ALLOC;
		row.idx = '0;
		row.fence = '0;
		row.cfg_val = fdsa_pkg::CNT_W'(val);
		row.typed = 1'b0;
		row.want = '0;
		dir_rows.push_back(row);
	endtask

	// offer one item, called at a falling edge, returns at a falling edge
	task automatic send_item(fdsa_pkg::opcode_t op, logic [fdsa_pkg::SLOT_W-1:0] idx,
		logic [fdsa_pkg::FENCE_W-1:0] fence, bit typed, reply_t want);
		reply_t pred;
		while ($urandom_range(0, 99) < send_idle) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.opcode = op;
		req_ch.slot_index = idx;
		req_ch.fence_value = fence;
		do @(posedge clk); while (!req_ch.ready);
		pred = allocator_reply(op, idx, fence);
		reply_fifo.push_back(typed ? want : pred);
		@(negedge clk);
	endtask

	// capacity write, only once every reply is back
	task automatic write_capacity(logic [fdsa_pkg::CNT_W-1:0] val);
		req_ch.valid = 1'b0;
		while (reply_fifo.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (val != '0) cap_reg = val;
	endtask

	task automatic set_idle(int s, int r, int hold);
		@(posedge clk);
		send_idle = s;
		recv_idle = r;
		hold_left = hold;
		@(negedge clk);
	endtask

	// random traffic: allocates, releases mostly of held slots with ordered fences, retires and queries
	task automatic run_random(int n);
		fdsa_pkg::opcode_t op;
		logic [fdsa_pkg::SLOT_W-1:0] idx;
		logic [fdsa_pkg::FENCE_W-1:0] fence;
		logic [fdsa_pkg::SLOT_W-1:0] held [$];
		int pick;
		int cap;
		int k;
		int s;
		reply_t none;
		none = '0;
		for (k = 0; k < n; k++) begin
			held.delete();
			for (s = 0; s < fdsa_pkg::SLOT_COUNT; s++) begin
				if (alloc_flag[s]) held.push_back(fdsa_pkg::SLOT_W'(s));
			end
			cap = eff_capacity();
			pick = $urandom_range(0, 99);
			idx = $urandom_range(0, 1)
				? fdsa_pkg::SLOT_W'($urandom_range(0, fdsa_pkg::SLOT_COUNT - 1))
				: fdsa_pkg::SLOT_W'($urandom_range(0, cap - 1));
			fence = {$urandom, $urandom};
			if (pick < 36) begin
				op = fdsa_pkg::OP_ALLOC;
			end else if (pick < 66) begin
				op = fdsa_pkg::OP_RELEASE;
				if (held.size() > 0 && $urandom_range(0, 99) < 85)
					idx = held[$urandom_range(0, held.size() - 1)];
				if ($urandom_range(0, 99) >= 6)
					fence = fence_now + fdsa_pkg::FENCE_W'($urandom_range(0, 40));
			end else if (pick < 84) begin
				op = fdsa_pkg::OP_RETIRE;
				pick = $urandom_range(0, 99);
				if (pick < 5) begin
					fence = FENCE_MAX;
				end else if (pick >= 10) begin
					fence = fence_now;
				end
				fence_now = fence_now + fdsa_pkg::FENCE_W'($urandom_range(0, 12));
			end else begin
				op = fdsa_pkg::OP_QUERY;
				if (held.size() > 0 && $urandom_range(0, 99) < 60)
					idx = held[$urandom_range(0, held.size() - 1)];
			end
			send_item(op, idx, fence, 1'b0, none);
		end
	endtask

	// receiver: random ready, long hold-off on request, reply check
	initial begin
		reply_t want;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				rsp_ch.ready = 1'b0;
				hold_left--;
			end else begin
				rsp_ch.ready = ($urandom_range(0, 99) >= recv_idle);
			end
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				if (reply_fifo.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: reply with no request outstanding", $time);
				end else begin
					want = reply_fifo.pop_front();
					if (rsp_ch.status !== want.status || rsp_ch.granted_slot !== want.granted
						|| rsp_ch.is_allocated !== want.alloc
						|| rsp_ch.used_count !== want.used
						|| rsp_ch.retired_count !== want.retired) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"%0t: reply differs, want st=%0d slot=%0d alloc=%0d ",
								"used=%0d retired=%0d, got st=%0d slot=%0d alloc=%0d ",
								"used=%0d retired=%0d"}, $time, want.status, want.granted,
								want.alloc, want.used, want.retired, rsp_ch.status,
								rsp_ch.granted_slot, rsp_ch.is_allocated,
								rsp_ch.used_count, rsp_ch.retired_count);
					end
				end
			end
		end
	end

	// watchdog
	initial begin
		#1000000;
		$display("fence_deferred_slot_allocator: mismatch");
		$finish;
	end

	// main sequence
	initial begin
		int r;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.opcode = fdsa_pkg::OP_ALLOC;
		req_ch.slot_index = '0;
		req_ch.fence_value = '0;
		cap_reg = fdsa_pkg::CNT_W'(fdsa_pkg::SLOT_COUNT);
		for (r = 0; r < fdsa_pkg::SLOT_COUNT; r++) alloc_flag[r] = 1'b0;
		bump_ptr = '0;
		in_use = '0;

		// after reset: empty state, bump pointer from zero
		row_typed(fdsa_pkg::OP_QUERY, 0, 64'd0, fdsa_pkg::ST_OK, 0, 1'b0, 0, 0);
		row_typed(fdsa_pkg::OP_RELEASE, 5, 64'd0, fdsa_pkg::ST_DOUBLE, 0, 1'b0, 0, 0);
		row_typed(fdsa_pkg::OP_RETIRE, 0, FENCE_MAX, fdsa_pkg::ST_OK, 0, 1'b0, 0, 0);
		row_typed(fdsa_pkg::OP_ALLOC, 0, 64'd0, fdsa_pkg::ST_OK, 0, 1'b0, 1, 0);
		row_item(fdsa_pkg::OP_ALLOC, 0, 64'd0);
		row_item(fdsa_pkg::OP_ALLOC, 0, 64'd0);
		row_item(fdsa_pkg::OP_QUERY, 1, 64'd0);
		row_item(fdsa_pkg::OP_RELEASE, 1, 64'd100);
		row_typed(fdsa_pkg::OP_RELEASE, 1, 64'd100, fdsa_pkg::ST_DOUBLE, 0, 1'b0, 2, 0);
		// smaller fence behind a larger one waits for it
		row_item(fdsa_pkg::OP_RELEASE, 2, 64'd50);
		row_item(fdsa_pkg::OP_RETIRE, 0, 64'd99);
		row_item(fdsa_pkg::OP_RETIRE, 0, 64'd100);
		row_item(fdsa_pkg::OP_ALLOC, 0, 64'd0);
		row_item(fdsa_pkg::OP_ALLOC, 0, 64'd0);
		row_item(fdsa_pkg::OP_ALLOC, 0, 64'd0);
		row_item(fdsa_pkg::OP_RELEASE, 0, 64'd0);
		row_item(fdsa_pkg::OP_RETIRE, 0, 64'd0);
		row_item(fdsa_pkg::OP_RELEASE, 3, FENCE_MAX);
		row_item(fdsa_pkg::OP_RETIRE, 0, FENCE_MAX - 64'd1);
		row_item(fdsa_pkg::OP_RETIRE, 0, FENCE_MAX);
		// lowest capacity: free list still drains, then full
		row_cfg(1);
		row_item(fdsa_pkg::OP_QUERY, 1, 64'd0);
		row_typed(fdsa_pkg::OP_RELEASE, 1023, 64'd0, fdsa_pkg::ST_RANGE, 0, 1'b0, 2, 0);
		row_item(fdsa_pkg::OP_ALLOC, 0, 64'd0);
		row_item(fdsa_pkg::OP_ALLOC, 0, 64'd0);
		row_typed(fdsa_pkg::OP_ALLOC, 1023, FENCE_MAX, fdsa_pkg::ST_FULL, 0, 1'b0, 4, 0);
		// zero write is dropped
		row_cfg(0);
		row_typed(fdsa_pkg::OP_ALLOC, 0, 64'd0, fdsa_pkg::ST_FULL, 0, 1'b0, 4, 0);
		// largest value acts as the full slot count
		row_cfg(2047);
		row_item(fdsa_pkg::OP_ALLOC, 0, 64'd0);
		row_typed(fdsa_pkg::OP_RELEASE, 1023, 64'd0, fdsa_pkg::ST_DOUBLE, 0, 1'b0, 5, 0);
		row_item(fdsa_pkg::OP_QUERY, 1023, FENCE_MAX);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		set_idle(8, 86, 0);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				write_capacity(dir_rows[i].cfg_val);
			end else begin
				send_item(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].fence,
					dir_rows[i].typed, dir_rows[i].want);
			end
		end

		// random phases
		write_capacity(fdsa_pkg::CNT_W'(fdsa_pkg::SLOT_COUNT));
		run_random(250);
		write_capacity(fdsa_pkg::CNT_W'(5));
		set_idle(86, 8, 0);
		run_random(250);
		write_capacity(fdsa_pkg::CNT_W'(1025));
		set_idle(0, 0, 300);
		run_random(250);

		// drain
		req_ch.valid = 1'b0;
		while (reply_fifo.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("fence_deferred_slot_allocator: match");
		else
			$display("fence_deferred_slot_allocator: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/fdsa_pkg.sv
hw/rtl/fdsa_req_if.sv
hw/rtl/fdsa_rsp_if.sv
hw/rtl/fdsa_ram.sv
hw/rtl/fence_deferred_slot_allocator.sv
tb/fence_deferred_slot_allocator_tb.sv
